### hw/rtl/hlpf_pkg.sv
`default_nettype none

package hlpf_pkg;

    // Default geometry and store shape
    localparam int DEF_THETA_STEPS = 180;
    localparam int DEF_RHO_BINS    = 397;
    localparam int DEF_VOTE_WIDTH  = 8;

    // Fixed image and rho geometry
    localparam int IMG_ROWS   = 128;
    localparam int IMG_COLS   = 128;
    localparam int RHO_OFFSET = 198;

    // Field widths
    localparam int COORD_W     = 7;
    localparam int RHO_W       = 9;
    localparam int THETA_OUT_W = 8;
    localparam int VOTES_OUT_W = 8;

    // Stream bus widths and field positions
    localparam int S_TDATA_W   = 16;
    localparam int ROW_LSB     = 0;
    localparam int COL_LSB     = COORD_W;
    localparam int M_TDATA_W   = 32;
    localparam int M_RHO_LSB   = 0;
    localparam int M_THETA_LSB = RHO_W;
    localparam int M_VOTES_LSB = RHO_W + THETA_OUT_W;
    localparam int M_USED_W    = RHO_W + THETA_OUT_W + VOTES_OUT_W;

    // Trig arithmetic
    localparam int SIN_W        = 16;
    localparam int SIN_ENTRIES  = 91;
    localparam int SIN_FRAC_W   = 14;
    localparam int DEG_W        = 9;
    localparam int DEG_FULL     = 360;
    localparam int DEG_QUARTER  = 90;
    localparam int PROD_W       = COORD_W + 1 + SIN_W;
    localparam int ACC_W        = PROD_W + 1;
    localparam int IDX_W        = 12;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef logic [SIN_ENTRIES*SIN_W-1:0] sin_table_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Quarter-wave sine in Q1.14, built from a Q30 Taylor series at elaboration
    function automatic sin_table_t build_sin_table();
        sin_table_t        tbl;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   q;
        longint            sum;
        int                k;
        tbl = '0;
        for (k = 0; k < SIN_ENTRIES; k++) begin
            x    = (PI_Q30 * longint'(k) + 64'd90) / 64'd180;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            // Terms x^3/3! up to x^25/25!, each from the one before
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd272;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd342;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd420;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd506;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd600;
            sum  = sum + longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            q = (longint'(sum) + 64'd32768) >> 16;
            tbl[k*SIN_W +: SIN_W] = SIN_W'(q);
        end
        return tbl;
    endfunction

    localparam sin_table_t SIN_TABLE = build_sin_table();

    // Sine of a whole degree in 0..359, Q1.14
    function automatic logic signed [SIN_W-1:0] sin_deg(input logic [DEG_W-1:0] d);
        logic [6:0]       k;
        logic             neg;
        logic [SIN_W-1:0] mag;
        if (d <= DEG_W'(90)) begin
            k   = 7'(d);
            neg = 1'b0;
        end else if (d <= DEG_W'(180)) begin
            k   = 7'(DEG_W'(180) - d);
            neg = 1'b0;
        end else if (d <= DEG_W'(270)) begin
            k   = 7'(d - DEG_W'(180));
            neg = 1'b1;
        end else begin
            k   = 7'(DEG_W'(DEG_FULL) - d);
            neg = 1'b1;
        end
        mag = SIN_TABLE[k*SIN_W +: SIN_W];
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/hough_line_peak_finder.sv
`default_nettype none

// Hough line peak finder. Edge pixels arrive in raster order; each edge pixel inside the
// image casts one vote per angle into a rho-by-theta vote store held in a single RAM with
// one read and one write port, and each vote is a read-modify-write through a six-stage
// pipeline. A voting pixel holds off further pixels until its last vote is written;
// a pixel that does not vote holds off none. On the frame_end pixel the block finishes
// that pixel's votes, then sweeps all RHO_BINS * THETA_STEPS cells of the store once,
// one cell per cycle, zeroing each cell as it is read, and emits one result: the first
// strictly greatest cell in rho-major order. After reset the store is zeroed by a sweep
// of the same length during which no pixel is taken. The result sits in an output
// register, so pixels of the next frame are taken while it waits for the downstream side.
module hough_line_peak_finder #(
    parameter int THETA_STEPS = hlpf_pkg::DEF_THETA_STEPS,
    parameter int RHO_BINS    = hlpf_pkg::DEF_RHO_BINS,
    parameter int VOTE_WIDTH  = hlpf_pkg::DEF_VOTE_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // pixel_row [6:0], pixel_col [13:7], zero fill
    input  wire logic [hlpf_pkg::S_TDATA_W-1:0] s_tdata,
    // is_edge
    input  wire logic                           s_tuser,
    // frame_end
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // line_rho [8:0], line_theta [16:9], peak_votes [24:17], zero fill
    output logic      [hlpf_pkg::M_TDATA_W-1:0] m_tdata,
    // found
    output logic                                m_tuser
);

    import hlpf_pkg::*;

    localparam int CELLS  = RHO_BINS * THETA_STEPS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int T_W    = (THETA_STEPS > 1) ? $clog2(THETA_STEPS) : 1;
    localparam int R_W    = $clog2(RHO_BINS);
    localparam int CMP_W  = (VOTE_WIDTH > VOTES_OUT_W) ? VOTE_WIDTH : VOTES_OUT_W;
    localparam logic [VOTE_WIDTH-1:0] VOTE_MAX = {VOTE_WIDTH{1'b1}};
    localparam logic [T_W-1:0]    T_LAST  = T_W'(THETA_STEPS - 1);
    localparam logic [ADDR_W-1:0] A_LAST  = ADDR_W'(CELLS - 1);

    state_t state_reg, state_next;

    logic                      pend_reg;
    logic [COORD_W-1:0]        row_reg, col_reg;

    // Angle generator
    logic                      gen_reg;
    logic [T_W-1:0]            t_reg;
    logic [DEG_W-1:0]          c_reg;

    // Vote pipeline
    logic                      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [SIN_W-1:0]   sin1_reg, cos1_reg;
    logic [T_W-1:0]            t1_reg, t2_reg, t3_reg;
    logic signed [PROD_W-1:0]  pa2_reg, pb2_reg;
    logic [R_W-1:0]            idx3_reg;
    logic [ADDR_W-1:0]         addr4_reg, addr5_reg;

    // Sweep
    logic [ADDR_W-1:0]         sa_reg;
    logic [R_W-1:0]            sr_reg, sc_r_reg, best_r_reg;
    logic [T_W-1:0]            st_reg, sc_t_reg, best_t_reg;
    logic                      sc_v_reg;
    logic [VOTE_WIDTH-1:0]     best_reg;

    // Result register
    logic                      m_valid_reg;
    logic [RHO_W-1:0]          m_rho_reg;
    logic [THETA_OUT_W-1:0]    m_theta_reg;
    logic [VOTES_OUT_W-1:0]    m_votes_reg;
    logic                      m_found_reg;

    logic                      busy, s_accept, vote_ok, sa_last, out_free, better;
    logic signed [ACC_W-1:0]   acc;
    logic [ACC_W-1:0]          mag, rnd;
    logic signed [IDX_W-1:0]   rho_s, idx_s;
    logic                      idx_ok;
    logic [ADDR_W-1:0]         addr_calc;

    logic                      ram_wr_en;
    logic [ADDR_W-1:0]         ram_wr_addr, ram_rd_addr;
    logic [VOTE_WIDTH-1:0]     ram_wr_data, ram_rd_data, vote_inc;

    assign busy     = gen_reg | v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign s_tready = (state_reg == ST_RUN) && !busy && !pend_reg;
    assign s_accept = s_tvalid && s_tready;
    assign vote_ok  = s_tuser
                   && ({1'b0, s_tdata[ROW_LSB +: COORD_W]} < (COORD_W + 1)'(IMG_ROWS))
                   && ({1'b0, s_tdata[COL_LSB +: COORD_W]} < (COORD_W + 1)'(IMG_COLS));
    assign sa_last  = (sa_reg == A_LAST);
    assign out_free = !m_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sa_last) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (pend_reg && !busy) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (sa_last) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) state_next = ST_RUN;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Round the rho sum half away from zero and place it in the store
    always_comb begin
        acc       = {pa2_reg[PROD_W-1], pa2_reg} + {pb2_reg[PROD_W-1], pb2_reg};
        mag       = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        rnd       = mag + ACC_W'(1 << (SIN_FRAC_W - 1));
        rho_s     = acc[ACC_W-1] ? -IDX_W'(rnd[ACC_W-1:SIN_FRAC_W])
                                 : IDX_W'(rnd[ACC_W-1:SIN_FRAC_W]);
        idx_s     = rho_s + IDX_W'(RHO_OFFSET);
        idx_ok    = !idx_s[IDX_W-1] && (idx_s < IDX_W'(RHO_BINS));
        addr_calc = ADDR_W'(idx3_reg) * ADDR_W'(THETA_STEPS) + ADDR_W'(t3_reg);
    end

    // Ports: sweeps own the write port, the scan the read port; else the vote pipeline
    assign vote_inc    = (ram_rd_data == VOTE_MAX) ? ram_rd_data
                                                   : VOTE_WIDTH'(ram_rd_data + 1'b1);
    assign ram_wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_SCAN) || v5_reg;
    assign ram_wr_addr = (state_reg == ST_CLEAR || state_reg == ST_SCAN) ? sa_reg : addr5_reg;
    assign ram_wr_data = (state_reg == ST_CLEAR || state_reg == ST_SCAN) ? '0 : vote_inc;
    assign ram_rd_addr = (state_reg == ST_SCAN) ? sa_reg : addr4_reg;

    assign better = sc_v_reg && (ram_rd_data > best_reg);

    hlpf_ram #(
        .WIDTH (VOTE_WIDTH),
        .DEPTH (CELLS)
    ) u_vote_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Control: pending frame end, angle generator, pipeline valids, sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            gen_reg     <= 1'b0;
            t_reg       <= '0;
            c_reg       <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            sa_reg      <= '0;
            sr_reg      <= '0;
            st_reg      <= '0;
            sc_v_reg    <= 1'b0;
            best_reg    <= '0;
            best_r_reg  <= '0;
            best_t_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Hold the frame end until its own votes drain
            if (s_accept && s_tlast) begin
                pend_reg <= 1'b1;
            end else if (state_reg == ST_RUN && state_next == ST_SCAN) begin
                pend_reg <= 1'b0;
            end

            // Step through the angles of one pixel
            if (s_accept && vote_ok) begin
                gen_reg <= 1'b1;
                t_reg   <= '0;
                c_reg   <= DEG_W'(DEG_QUARTER);
            end else if (gen_reg) begin
                if (t_reg == T_LAST) gen_reg <= 1'b0;
                t_reg <= t_reg + 1'b1;
                c_reg <= (c_reg == DEG_W'(DEG_FULL - 1)) ? '0 : c_reg + 1'b1;
            end

            v1_reg <= gen_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && idx_ok;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;

            // Advance the sweep address, and in the scan rho and theta alongside it
            if (state_reg == ST_CLEAR || state_reg == ST_SCAN) begin
                sa_reg <= sa_last ? '0 : sa_reg + 1'b1;
            end
            if (state_reg == ST_SCAN) begin
                if (sa_last) begin
                    sr_reg <= '0;
                    st_reg <= '0;
                end else if (st_reg == T_LAST) begin
                    sr_reg <= sr_reg + 1'b1;
                    st_reg <= '0;
                end else begin
                    st_reg <= st_reg + 1'b1;
                end
            end
            sc_v_reg <= (state_reg == ST_SCAN);

            // Track the first strictly greatest cell; drop it once reported
            if (state_reg == ST_FINISH && out_free) begin
                best_reg   <= '0;
                best_r_reg <= '0;
                best_t_reg <= '0;
            end else if (better) begin
                best_reg   <= ram_rd_data;
                best_r_reg <= sc_r_reg;
                best_t_reg <= sc_t_reg;
            end

            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Pipeline and result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            row_reg <= s_tdata[ROW_LSB +: COORD_W];
            col_reg <= s_tdata[COL_LSB +: COORD_W];
        end
        sin1_reg  <= sin_deg(DEG_W'(t_reg));
        cos1_reg  <= sin_deg(c_reg);
        t1_reg    <= t_reg;
        pa2_reg   <= $signed({1'b0, row_reg}) * cos1_reg;
        pb2_reg   <= $signed({1'b0, col_reg}) * sin1_reg;
        t2_reg    <= t1_reg;
        idx3_reg  <= R_W'(idx_s);
        t3_reg    <= t2_reg;
        addr4_reg <= addr_calc;
        addr5_reg <= addr4_reg;
        sc_r_reg  <= sr_reg;
        sc_t_reg  <= st_reg;

        if (state_reg == ST_FINISH && out_free) begin
            if (better) begin
                m_found_reg <= 1'b1;
                m_rho_reg   <= RHO_W'(sc_r_reg) - RHO_W'(RHO_OFFSET);
                m_theta_reg <= THETA_OUT_W'(sc_t_reg);
                m_votes_reg <= (CMP_W'(ram_rd_data) > CMP_W'(8'hFF))
                               ? 8'hFF : VOTES_OUT_W'(ram_rd_data);
            end else begin
                m_found_reg <= (best_reg != '0);
                m_rho_reg   <= (best_reg != '0) ? RHO_W'(best_r_reg) - RHO_W'(RHO_OFFSET)
                                                : '0;
                m_theta_reg <= THETA_OUT_W'(best_t_reg);
                m_votes_reg <= (CMP_W'(best_reg) > CMP_W'(8'hFF))
                               ? 8'hFF : VOTES_OUT_W'(best_reg);
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {(M_TDATA_W - M_USED_W)'(0), m_votes_reg, m_theta_reg, m_rho_reg};

endmodule

`default_nettype wire

### hw/rtl/hlpf_ram.sv
`default_nettype none

module hlpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read; a read of the entry being written sees old data
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hw/rtl/hlpf_checker.sv
`default_nettype none

module hlpf_checker #(
    parameter int THETA_STEPS = hlpf_pkg::DEF_THETA_STEPS
) (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           s_tlast,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [hlpf_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tuser
);

    import hlpf_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An empty frame reports all-zero fields
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("empty frame with nonzero fields");

    // A found line carries at least one vote
    a_found_votes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[M_VOTES_LSB +: VOTES_OUT_W] != '0)
        else $error("found line without votes");

    // Reported angle lies in the angle range
    a_theta_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[M_THETA_LSB +: THETA_OUT_W]) < 32'(THETA_STEPS))
        else $error("angle out of range");

    // A frame end transfer is checked to drop s_tready straight after it
    a_frame_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("pixel taken right after frame end");

endmodule

bind hough_line_peak_finder hlpf_checker #(
    .THETA_STEPS (THETA_STEPS)
) u_hlpf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
